FILE: src/stt_pkg.sv
package stt_pkg;

  // Result kinds
  localparam logic [1:0] RK_TOKEN   = 2'd0;
  localparam logic [1:0] RK_PAYLOAD = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;

  // Error kinds
  localparam logic [2:0] ERR_ILLEGAL     = 3'd0;
  localparam logic [2:0] ERR_SECOND_DOT  = 3'd1;
  localparam logic [2:0] ERR_TRAIL_DOT   = 3'd2;
  localparam logic [2:0] ERR_UNTERM_STR  = 3'd3;
  localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd4;

  // Token kinds
  localparam logic [7:0] TK_INT     = 8'd0;
  localparam logic [7:0] TK_FLOAT   = 8'd1;
  localparam logic [7:0] TK_STRING  = 8'd2;
  localparam logic [7:0] TK_IDENT   = 8'd3;
  localparam logic [7:0] TK_KEYWORD = 8'd4;
  localparam logic [7:0] TK_PLUS    = 8'd5;
  localparam logic [7:0] TK_MINUS   = 8'd6;
  localparam logic [7:0] TK_STAR    = 8'd7;
  localparam logic [7:0] TK_SLASH   = 8'd8;
  localparam logic [7:0] TK_PERCENT = 8'd9;
  localparam logic [7:0] TK_ADD_EQ  = 8'd10;
  localparam logic [7:0] TK_SUB_EQ  = 8'd11;
  localparam logic [7:0] TK_MUL_EQ  = 8'd12;
  localparam logic [7:0] TK_DIV_EQ  = 8'd13;
  localparam logic [7:0] TK_INC     = 8'd14;
  localparam logic [7:0] TK_DEC     = 8'd15;
  localparam logic [7:0] TK_ASSIGN  = 8'd16;
  localparam logic [7:0] TK_EQ      = 8'd17;
  localparam logic [7:0] TK_NE      = 8'd18;
  localparam logic [7:0] TK_LT      = 8'd19;
  localparam logic [7:0] TK_LE      = 8'd20;
  localparam logic [7:0] TK_GT      = 8'd21;
  localparam logic [7:0] TK_GE      = 8'd22;
  localparam logic [7:0] TK_LAND    = 8'd23;
  localparam logic [7:0] TK_LOR     = 8'd24;
  localparam logic [7:0] TK_NOT     = 8'd25;
  localparam logic [7:0] TK_AMP     = 8'd26;
  localparam logic [7:0] TK_PIPE    = 8'd27;
  localparam logic [7:0] TK_TILDE   = 8'd28;
  localparam logic [7:0] TK_CARET   = 8'd29;
  localparam logic [7:0] TK_LPAREN  = 8'd30;
  localparam logic [7:0] TK_RPAREN  = 8'd31;
  localparam logic [7:0] TK_LBRACK  = 8'd32;
  localparam logic [7:0] TK_RBRACK  = 8'd33;
  localparam logic [7:0] TK_LBRACE  = 8'd34;
  localparam logic [7:0] TK_RBRACE  = 8'd35;
  localparam logic [7:0] TK_COMMA   = 8'd36;
  localparam logic [7:0] TK_DOT     = 8'd37;
  localparam logic [7:0] TK_SEMI    = 8'd38;
  localparam logic [7:0] TK_SPACE   = 8'd39;
  localparam logic [7:0] TK_NEWLINE = 8'd40;
  localparam logic [7:0] TK_EOF     = 8'd41;
  localparam logic [7:0] TK_NONE    = 8'hFF;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned NumKeywords = 14;
  localparam int unsigned KeywordChars = 8;

  // Keyword text, first character in the top byte, zero padded
  localparam logic [NumKeywords-1:0][8*KeywordChars-1:0] KW_TEXT = '{
    {"class", 24'h0}, {"lambda", 16'h0}, {"fun", 40'h0}, {"break", 24'h0},
    "continue", {"return", 16'h0}, {"this", 32'h0}, {"const", 24'h0},
    {"var", 40'h0}, {"for", 40'h0}, {"while", 24'h0}, {"else", 32'h0},
    {"elif", 32'h0}, {"if", 48'h0}
  };
  localparam logic [NumKeywords-1:0][3:0] KW_LEN = '{
    4'd5, 4'd6, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd5, 4'd3, 4'd3, 4'd5, 4'd4, 4'd4, 4'd2
  };

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [5:0]  token_kind;
    logic [2:0]  error_kind;
    logic [15:0] start_index;
    logic [15:0] end_index;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  payload_byte;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [2:0]            count;
  } bundle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == "_");
  endfunction

  function automatic logic [7:0] op_pair(logic [7:0] a, logic [7:0] b);
    logic [7:0] tk;
    tk = TK_NONE;
    if (b == "=") begin
      case (a)
        ">": tk = TK_GE;
        "<": tk = TK_LE;
        "!": tk = TK_NE;
        "=": tk = TK_EQ;
        "*": tk = TK_MUL_EQ;
        "/": tk = TK_DIV_EQ;
        "+": tk = TK_ADD_EQ;
        "-": tk = TK_SUB_EQ;
        default: tk = TK_NONE;
      endcase
    end else if (a == b) begin
      case (a)
        "+": tk = TK_INC;
        "-": tk = TK_DEC;
        "&": tk = TK_LAND;
        "|": tk = TK_LOR;
        default: tk = TK_NONE;
      endcase
    end
    return tk;
  endfunction

  function automatic logic [7:0] op_single(logic [7:0] a);
    logic [7:0] tk;
    case (a)
      ">": tk = TK_GT;
      "<": tk = TK_LT;
      "!": tk = TK_NOT;
      "=": tk = TK_ASSIGN;
      "*": tk = TK_STAR;
      "/": tk = TK_SLASH;
      "+": tk = TK_PLUS;
      "-": tk = TK_MINUS;
      "&": tk = TK_AMP;
      "|": tk = TK_PIPE;
      default: tk = TK_NONE;
    endcase
    return tk;
  endfunction

  function automatic logic [7:0] plain_single(logic [7:0] c);
    logic [7:0] tk;
    case (c)
      ";": tk = TK_SEMI;
      "[": tk = TK_LBRACK;
      "]": tk = TK_RBRACK;
      "{": tk = TK_LBRACE;
      "}": tk = TK_RBRACE;
      ",": tk = TK_COMMA;
      ".": tk = TK_DOT;
      "%": tk = TK_PERCENT;
      "~": tk = TK_TILDE;
      "^": tk = TK_CARET;
      "(": tk = TK_LPAREN;
      ")": tk = TK_RPAREN;
      " ", "\t": tk = TK_SPACE;
      "\n": tk = TK_NEWLINE;
      default: tk = TK_NONE;
    endcase
    return tk;
  endfunction

endpackage

FILE: src/stt_if.sv
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [5:0]  token_kind;
  logic [2:0]  error_kind;
  logic [15:0] start_index;
  logic [15:0] end_index;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [7:0]  payload_byte;
  logic        last_result;

  modport source (output valid, output result_kind, output token_kind, output error_kind,
                  output start_index, output end_index, output start_line,
                  output start_column, output payload_byte, output last_result,
                  input ready);
  modport sink (input valid, input result_kind, input token_kind, input error_kind,
                input start_index, input end_index, input start_line,
                input start_column, input payload_byte, input last_result,
                output ready);
endinterface

FILE: src/source_text_tokenizer.sv
// Streaming tokenizer: one source byte in per transfer on src_i, results out on res_o.
// src_i carries char_byte and end_of_text; a zero byte or end_of_text closes the text,
// flushes any open token, emits an EOF token and restarts positions at zero.
// res_o carries tokens, decoded string bytes and error reports with start and end
// index, line and column; last_result marks the final result of one input byte.
// Each byte is lexed in the cycle it is transferred; its results (zero to three)
// are registered and appear on res_o from the next cycle, one per cycle while
// res_o is ready. Throughput is one byte per cycle while each byte yields at most one
// result; a byte with more holds the input until the single result port sends its last.
// src_i.ready stays high while the result register drains its last entry, so bytes
// follow back to back. When res_o stalls, results hold and src_i waits.
// Reset clears position, lexer mode and the result count; word characters and result
// entries are written before they are read and carry no reset.
module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned KEYWORD_MAX_LENGTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  stt_in_if.sink    src_i,
  stt_out_if.source res_o
);

  stt_pkg::bundle_t bundle;
  stt_pkg::res_t    cur;
  logic             accept;
  logic             in_ready;

  assign src_i.ready = in_ready;
  assign accept      = src_i.valid && in_ready;

  stt_core #(
    .PositionBits(POSITION_BITS),
    .KeywordMaxLength(KEYWORD_MAX_LENGTH)
  ) u_core (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .char_byte_i(src_i.char_byte),
    .end_of_text_i(src_i.end_of_text),
    .bundle_o(bundle)
  );

  stt_outq u_outq (
    .clk_i, .rst_ni,
    .load_i(accept),
    .bundle_i(bundle),
    .out_ready_i(res_o.ready),
    .out_valid_o(res_o.valid),
    .out_res_o(cur),
    .out_last_o(res_o.last_result),
    .in_ready_o(in_ready)
  );

  // Drive result fields
  assign res_o.result_kind  = cur.result_kind;
  assign res_o.token_kind   = cur.token_kind;
  assign res_o.error_kind   = cur.error_kind;
  assign res_o.start_index  = cur.start_index;
  assign res_o.end_index    = cur.end_index;
  assign res_o.start_line   = cur.start_line;
  assign res_o.start_column = cur.start_column;
  assign res_o.payload_byte = cur.payload_byte;

endmodule

FILE: src/stt_kwmatch.sv
module stt_kwmatch #(
  parameter int unsigned KeywordMaxLength = 8,
  parameter int unsigned LenBits = 4
) (
  input  logic [KeywordMaxLength-1:0][7:0] word_i,
  input  logic [LenBits-1:0]               len_i,
  output logic                             hit_o
);

  // Compare the written prefix of the word against every keyword
  always_comb begin
    logic ok;
    hit_o = 1'b0;
    for (int k = 0; k < stt_pkg::NumKeywords; k++) begin
      ok = (len_i == LenBits'(stt_pkg::KW_LEN[k]));
      for (int i = 0; i < stt_pkg::KeywordChars; i++) begin
        if (i < int'(stt_pkg::KW_LEN[k]) &&
            word_i[i] != stt_pkg::KW_TEXT[k][8*stt_pkg::KeywordChars-1-8*i -: 8]) begin
          ok = 1'b0;
        end
      end
      if (ok) hit_o = 1'b1;
    end
  end

endmodule

FILE: src/stt_core.sv
module stt_core #(
  parameter int unsigned PositionBits = 16,
  parameter int unsigned KeywordMaxLength = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_byte_i,
  input  logic             end_of_text_i,
  output stt_pkg::bundle_t bundle_o
);

  localparam int unsigned LenBits = $clog2(KeywordMaxLength + 2);
  localparam int unsigned IdxBits = $clog2(KeywordMaxLength);
  localparam logic [PositionBits-1:0] PosMax = '1;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_NUM, M_WORD, M_STR, M_ESC, M_SKIP, M_DOTSKIP, M_COMMENT
  } mode_e;

  typedef logic [PositionBits-1:0] pos_t;

  mode_e                           mode_q, mode_d;
  logic [7:0]                      pend_q, pend_d;
  pos_t                            tsi_q, tsi_d, tsl_q, tsl_d, tsc_q, tsc_d;
  pos_t                            ci_q, ci_d, cl_q, cl_d, cc_q, cc_d;
  logic                            sd_q, sd_d, ld_q, ld_d;
  logic [LenBits-1:0]              wlen_q, wlen_d, wlen_ext;
  logic [KeywordMaxLength-1:0][7:0] wbuf_q, wbuf_d, wbuf_ext;
  logic                            kw_cur, kw_ext;

  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? v : v + pos_t'(1);
  endfunction

  function automatic stt_pkg::res_t mk(logic [1:0] rk, logic [7:0] tk, logic [2:0] ek,
                                       pos_t si, pos_t ei, pos_t sl, pos_t sc,
                                       logic [7:0] pb);
    stt_pkg::res_t r;
    r.result_kind  = rk;
    r.token_kind   = tk[5:0];
    r.error_kind   = ek;
    r.start_index  = 16'(si);
    r.end_index    = 16'(ei);
    r.start_line   = 16'(sl);
    r.start_column = 16'(sc);
    r.payload_byte = pb;
    return r;
  endfunction

  // Word as it stands if this byte extends it, for the close at end of text
  always_comb begin
    wbuf_ext = wbuf_q;
    wlen_ext = wlen_q;
    if (mode_q == M_WORD && stt_pkg::is_word(char_byte_i)) begin
      if (wlen_q < LenBits'(KeywordMaxLength)) wbuf_ext[wlen_q[IdxBits-1:0]] = char_byte_i;
      if (wlen_q <= LenBits'(KeywordMaxLength)) wlen_ext = wlen_q + LenBits'(1);
    end
  end

  stt_kwmatch #(.KeywordMaxLength(KeywordMaxLength), .LenBits(LenBits)) u_kw_cur (
    .word_i(wbuf_q), .len_i(wlen_q), .hit_o(kw_cur)
  );

  stt_kwmatch #(.KeywordMaxLength(KeywordMaxLength), .LenBits(LenBits)) u_kw_ext (
    .word_i(wbuf_ext), .len_i(wlen_ext), .hit_o(kw_ext)
  );

  // One step of the lexer: up to three results for this byte
  always_comb begin
    logic [7:0]       c;
    logic [7:0]       tk;
    logic             do_start;
    logic [2:0]       n;
    stt_pkg::res_t [stt_pkg::MaxResults-1:0] r;

    c        = char_byte_i;
    tk       = stt_pkg::TK_NONE;
    do_start = 1'b0;
    n        = '0;
    r        = '0;
    mode_d = mode_q; pend_d = pend_q;
    tsi_d = tsi_q; tsl_d = tsl_q; tsc_d = tsc_q;
    ci_d = ci_q; cl_d = cl_q; cc_d = cc_q;
    sd_d = sd_q; ld_d = ld_q; wlen_d = wlen_q; wbuf_d = wbuf_q;

    if (c != 8'h0) begin
      case (mode_q)
        M_OP: begin
          if (pend_q == "/" && c == "/") begin
            mode_d = M_COMMENT;
          end else begin
            tk = stt_pkg::op_pair(pend_q, c);
            if (tk != stt_pkg::TK_NONE) begin
              r[n[1:0]] = mk(stt_pkg::RK_TOKEN, tk, '0, tsi_d, sat_inc(ci_d), tsl_d, tsc_d, '0);
              n = n + 3'd1;
              mode_d = M_IDLE;
            end else begin
              r[n[1:0]] = mk(stt_pkg::RK_TOKEN, stt_pkg::op_single(pend_q), '0, tsi_d,
                             sat_inc(tsi_d), tsl_d, tsc_d, '0);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end
        end
        M_NUM: begin
          if (stt_pkg::is_digit(c)) begin
            ld_d = 1'b0;
          end else if (c == ".") begin
            if (!sd_q) begin
              sd_d = 1'b1;
              ld_d = 1'b1;
            end else begin
              tsi_d = ci_d; tsl_d = cl_d; tsc_d = cc_d;
              mode_d = M_DOTSKIP;
            end
          end else begin
            if (ld_q) r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_TRAIL_DOT, tsi_d,
                                     ci_d, tsl_d, tsc_d, '0);
            else r[n[1:0]] = mk(stt_pkg::RK_TOKEN, sd_q ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT,
                                '0, tsi_d, ci_d, tsl_d, tsc_d, '0);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        M_WORD: begin
          if (stt_pkg::is_word(c)) begin
            wbuf_d = wbuf_ext;
            wlen_d = wlen_ext;
          end else begin
            r[n[1:0]] = mk(stt_pkg::RK_TOKEN, kw_cur ? stt_pkg::TK_KEYWORD : stt_pkg::TK_IDENT,
                           '0, tsi_d, ci_d, tsl_d, tsc_d, '0);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            r[n[1:0]] = mk(stt_pkg::RK_TOKEN, stt_pkg::TK_STRING, '0, tsi_d, sat_inc(ci_d),
                           tsl_d, tsc_d, '0);
            n = n + 3'd1;
            mode_d = M_IDLE;
          end else if (c == "\n") begin
            r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_UNTERM_STR, tsi_d, ci_d,
                           tsl_d, tsc_d, '0);
            n = n + 3'd1;
            do_start = 1'b1;
          end else if (c == "\\") begin
            mode_d = M_ESC;
          end else begin
            r[n[1:0]] = mk(stt_pkg::RK_PAYLOAD, '0, '0, ci_d, sat_inc(ci_d), cl_d, cc_d, c);
            n = n + 3'd1;
          end
        end
        M_ESC: begin
          if (c == "\n") begin
            r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_UNTERM_STR, tsi_d, ci_d,
                           tsl_d, tsc_d, '0);
            n = n + 3'd1;
            do_start = 1'b1;
          end else if (c == "n" || c == "t" || c == "r" || c == "a" || c == "\\") begin
            case (c)
              "n":     tk = 8'd10;
              "t":     tk = 8'd9;
              "r":     tk = 8'd13;
              "a":     tk = 8'd7;
              default: tk = 8'd92;
            endcase
            r[n[1:0]] = mk(stt_pkg::RK_PAYLOAD, '0, '0, ci_d, sat_inc(ci_d), cl_d, cc_d, tk);
            n = n + 3'd1;
            mode_d = M_STR;
          end else begin
            tsi_d = ci_d; tsl_d = cl_d; tsc_d = cc_d;
            r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_BAD_ESCAPE, tsi_d,
                           sat_inc(ci_d), tsl_d, tsc_d, '0);
            n = n + 3'd1;
            mode_d = M_SKIP;
          end
        end
        M_SKIP: mode_d = M_IDLE;
        M_DOTSKIP: begin
          r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_SECOND_DOT, tsi_d,
                         sat_inc(ci_d), tsl_d, tsc_d, '0);
          n = n + 3'd1;
          mode_d = M_IDLE;
        end
        M_COMMENT: begin
          if (c == "\n") mode_d = M_IDLE;
        end
        default: do_start = 1'b1;
      endcase

      // Begin a new item at this byte
      if (do_start) begin
        mode_d = M_IDLE;
        tsi_d = ci_d; tsl_d = cl_d; tsc_d = cc_d;
        if (stt_pkg::is_digit(c)) begin
          mode_d = M_NUM;
          sd_d = 1'b0;
          ld_d = 1'b0;
        end else if (stt_pkg::is_alpha(c) || c == "_") begin
          mode_d = M_WORD;
          wbuf_d[0] = c;
          wlen_d = LenBits'(1);
        end else if (c == "\"") begin
          mode_d = M_STR;
        end else if (stt_pkg::op_single(c) != stt_pkg::TK_NONE) begin
          mode_d = M_OP;
          pend_d = c;
        end else if (stt_pkg::plain_single(c) != stt_pkg::TK_NONE) begin
          r[n[1:0]] = mk(stt_pkg::RK_TOKEN, stt_pkg::plain_single(c), '0, tsi_d,
                         sat_inc(ci_d), tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end else begin
          r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_ILLEGAL, tsi_d, sat_inc(ci_d),
                         tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
      end

      // Advance the position past this byte
      ci_d = sat_inc(ci_d);
      if (c == "\n") begin
        cl_d = sat_inc(cl_d);
        cc_d = '0;
      end else begin
        cc_d = sat_inc(cc_d);
      end
    end

    // Close any open item, emit EOF and return to the reset state
    if (c == 8'h0 || end_of_text_i) begin
      case (mode_d)
        M_OP: begin
          r[n[1:0]] = mk(stt_pkg::RK_TOKEN, stt_pkg::op_single(pend_d), '0, tsi_d,
                         sat_inc(tsi_d), tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
        M_NUM: begin
          if (ld_d) r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_TRAIL_DOT, tsi_d,
                                   ci_d, tsl_d, tsc_d, '0);
          else r[n[1:0]] = mk(stt_pkg::RK_TOKEN, sd_d ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT,
                              '0, tsi_d, ci_d, tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
        M_WORD: begin
          r[n[1:0]] = mk(stt_pkg::RK_TOKEN,
                         (wlen_d != LenBits'(1) && kw_ext) ? stt_pkg::TK_KEYWORD
                                                           : stt_pkg::TK_IDENT,
                         '0, tsi_d, ci_d, tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
        M_STR, M_ESC: begin
          r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_UNTERM_STR, tsi_d, ci_d,
                         tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
        M_DOTSKIP: begin
          r[n[1:0]] = mk(stt_pkg::RK_ERROR, '0, stt_pkg::ERR_SECOND_DOT, tsi_d, ci_d,
                         tsl_d, tsc_d, '0);
          n = n + 3'd1;
        end
        default: ;
      endcase
      r[n[1:0]] = mk(stt_pkg::RK_TOKEN, stt_pkg::TK_EOF, '0, ci_d, ci_d, cl_d, cc_d, '0);
      n = n + 3'd1;
      mode_d = M_IDLE; pend_d = '0;
      tsi_d = '0; tsl_d = '0; tsc_d = '0;
      ci_d = '0; cl_d = '0; cc_d = '0;
      sd_d = 1'b0; ld_d = 1'b0; wlen_d = '0;
    end

    bundle_o.res   = r;
    bundle_o.count = n;
  end

  // Hold lexer state, advance on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      tsi_q  <= '0;
      tsl_q  <= '0;
      tsc_q  <= '0;
      ci_q   <= '0;
      cl_q   <= '0;
      cc_q   <= '0;
      sd_q   <= 1'b0;
      ld_q   <= 1'b0;
      wlen_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      tsi_q  <= tsi_d;
      tsl_q  <= tsl_d;
      tsc_q  <= tsc_d;
      ci_q   <= ci_d;
      cl_q   <= cl_d;
      cc_q   <= cc_d;
      sd_q   <= sd_d;
      ld_q   <= ld_d;
      wlen_q <= wlen_d;
    end
  end

  // Word characters carry no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) wbuf_q <= wbuf_d;
  end

endmodule

FILE: src/stt_outq.sv
module stt_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  stt_pkg::bundle_t bundle_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output stt_pkg::res_t    out_res_o,
  output logic             out_last_o,
  output logic             in_ready_o
);

  stt_pkg::res_t [stt_pkg::MaxResults-1:0] res_q;
  logic [2:0] cnt_q;
  logic [1:0] ptr_q;
  logic       take;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_res_o   = res_q[ptr_q];
  assign out_last_o  = ({1'b0, ptr_q} == cnt_q - 3'd1);
  assign take        = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (take && out_last_o);

  // Hold results of one byte, hand them out one per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else if (load_i && bundle_i.count != 3'd0) begin
      cnt_q <= bundle_i.count;
      ptr_q <= '0;
    end else if (take) begin
      if (out_last_o) cnt_q <= '0;
      ptr_q <= out_last_o ? 2'd0 : ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && bundle_i.count != 3'd0) res_q <= bundle_i.res;
  end

endmodule
